>>> hdl/pfci_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, command codes and default settings of the flash command interface.
package pfci_pkg;

    localparam int ADDR_BITS_DEFAULT    = 19;
    localparam int SECTOR_BYTES_DEFAULT = 128;
    localparam int ADDR_EXT_BITS        = 24;
    localparam int LOW_ADDR_BITS        = 12;

    localparam logic [7:0] PROGRAM_TICKS_RESET = 8'd20;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [11:0] UNLOCK_ADDR1 = 12'h555;
    localparam logic [11:0] UNLOCK_ADDR2 = 12'h2AA;

    localparam logic [7:0] CMD_UNLOCK1     = 8'hAA;
    localparam logic [7:0] CMD_UNLOCK2     = 8'h55;
    localparam logic [7:0] CMD_PROGRAM     = 8'hA0;
    localparam logic [7:0] CMD_ERASE_SETUP = 8'h80;
    localparam logic [7:0] CMD_CHIP_ERASE  = 8'h10;
    localparam logic [7:0] CMD_SECT_ERASE  = 8'h20;

    localparam logic [7:0] STATUS_TOGGLE = 8'h40;
    localparam logic [7:0] ERASED_BYTE   = 8'hFF;

    typedef enum logic [2:0] {
        PH_READ,
        PH_UNLOCK1,
        PH_CMD,
        PH_PROGRAM,
        PH_ESETUP,
        PH_EUNLOCK1,
        PH_EUNLOCK2
    } phase_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_WAIT,
        ST_PROG_WRITE
    } state_t;

endpackage
`default_nettype wire

>>> hdl/pfci_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic single-write, single-read synchronous RAM with registered read data.
module pfci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> hdl/parallel_flash_command_interface_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the parallel flash command interface: command decoder around the byte array RAM.
//
// Each request on the input channel (in_valid, in_stall) is a bus read, a bus write or a
// time tick; each one produces exactly one result on the output channel (out_valid,
// out_stall) carrying read_byte and busy_res. Writes are decoded by the unlock and command
// sequence; programs AND the data into the addressed byte and erases set one byte per tick.
// Writes, ticks and reads while busy are answered from the request itself; an idle read waits in
// ST_READ_WAIT, because the array RAM registers its read data, and a byte program passes through
// ST_PROG_WRITE for its read-modify-write on the single RAM write port.
// The result register lets a new request be accepted in the same cycle as the previous
// result is taken. While the receiver stalls a waiting result, in_stall stays high.
// After reset the block clears the array to 0xFF, one byte a cycle, all 2**ADDR_BITS bytes
// (524288 at the default setting), and holds in_stall high during that pass.
// The program busy time register is written through cfg_wr_en and cfg_wr_data at any time.
module parallel_flash_command_interface_top #(
    parameter int ADDR_BITS    = pfci_pkg::ADDR_BITS_DEFAULT,
    parameter int SECTOR_BYTES = pfci_pkg::SECTOR_BYTES_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [18:0] address,
    input  wire logic [7:0]  write_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [7:0]  read_byte,
    output logic             busy_res,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data
);

    localparam int DEPTH = 2 ** ADDR_BITS;
    localparam logic [ADDR_BITS-1:0] SECTOR_MASK = ADDR_BITS'(SECTOR_BYTES - 1);

    pfci_pkg::state_t state_reg, state_next;
    pfci_pkg::phase_t phase_reg, phase_next;

    logic [7:0]           busy_count_reg, busy_count_next;
    logic [ADDR_BITS-1:0] erase_ptr_reg, erase_ptr_next;
    logic [ADDR_BITS-1:0] erase_end_reg, erase_end_next;
    logic                 erase_run_reg, erase_run_next;
    logic                 toggle_reg, toggle_next;
    logic [7:0]           ticks_cfg_reg;
    logic [ADDR_BITS-1:0] clear_addr_reg, clear_addr_next;
    logic [ADDR_BITS-1:0] prog_addr_reg, prog_addr_next;
    logic [7:0]           prog_data_reg, prog_data_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_read_reg, out_read_next;
    logic                 out_busy_reg, out_busy_next;

    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_waddr;
    logic [7:0]           ram_wdata;
    logic                 ram_re;
    logic [ADDR_BITS-1:0] ram_raddr;
    logic [7:0]           ram_rdata;

    logic [pfci_pkg::ADDR_EXT_BITS-1:0] addr_ext;
    logic [ADDR_BITS-1:0]               addr;
    logic [11:0]                        addr_low;
    logic                               accept;
    logic                               busy;
    logic                               imm_load;
    logic [7:0]                         imm_read;

    assign addr_ext = pfci_pkg::ADDR_EXT_BITS'(address);
    assign addr     = addr_ext[ADDR_BITS-1:0];
    assign addr_low = addr[pfci_pkg::LOW_ADDR_BITS-1:0];
    assign busy     = erase_run_reg || (busy_count_reg != 8'd0);

    assign in_stall  = !((state_reg == pfci_pkg::ST_IDLE) && (!out_valid_reg || !out_stall));
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign read_byte = out_read_reg;
    assign busy_res  = out_busy_reg;

    pfci_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_array (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_en  (ram_re),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pfci_pkg::ST_CLEAR;
            phase_reg      <= pfci_pkg::PH_READ;
            busy_count_reg <= 8'd0;
            erase_ptr_reg  <= '0;
            erase_end_reg  <= '0;
            erase_run_reg  <= 1'b0;
            toggle_reg     <= 1'b0;
            ticks_cfg_reg  <= pfci_pkg::PROGRAM_TICKS_RESET;
            clear_addr_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            busy_count_reg <= busy_count_next;
            erase_ptr_reg  <= erase_ptr_next;
            erase_end_reg  <= erase_end_next;
            erase_run_reg  <= erase_run_next;
            toggle_reg     <= toggle_next;
            clear_addr_reg <= clear_addr_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                ticks_cfg_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prog_addr_reg <= prog_addr_next;
        prog_data_reg <= prog_data_next;
        out_read_reg  <= out_read_next;
        out_busy_reg  <= out_busy_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        busy_count_next = busy_count_reg;
        erase_ptr_next  = erase_ptr_reg;
        erase_end_next  = erase_end_reg;
        erase_run_next  = erase_run_reg;
        toggle_next     = toggle_reg;
        clear_addr_next = clear_addr_reg;
        prog_addr_next  = prog_addr_reg;
        prog_data_next  = prog_data_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_read_next   = out_read_reg;
        out_busy_next   = out_busy_reg;
        ram_we          = 1'b0;
        ram_waddr       = clear_addr_reg;
        ram_wdata       = pfci_pkg::ERASED_BYTE;
        ram_re          = 1'b0;
        ram_raddr       = addr;
        imm_load        = 1'b0;
        imm_read        = 8'd0;

        case (state_reg)
            pfci_pkg::ST_CLEAR:
            begin
                ram_we          = 1'b1;
                clear_addr_next = clear_addr_reg + ADDR_BITS'(1);
                if (&clear_addr_reg)
                begin
                    state_next = pfci_pkg::ST_IDLE;
                end
            end
            pfci_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        pfci_pkg::KIND_READ:
                        begin
                            if (busy)
                            begin
                                imm_load    = 1'b1;
                                imm_read    = toggle_reg ? pfci_pkg::STATUS_TOGGLE : 8'd0;
                                toggle_next = !toggle_reg;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                state_next = pfci_pkg::ST_READ_WAIT;
                            end
                        end
                        pfci_pkg::KIND_WRITE:
                        begin
                            imm_load = 1'b1;
                            if (!busy)
                            begin
                                phase_next = pfci_pkg::PH_READ;
                                case (phase_reg)
                                    pfci_pkg::PH_READ:
                                    begin
                                        if (addr_low == pfci_pkg::UNLOCK_ADDR1
                                            && write_byte == pfci_pkg::CMD_UNLOCK1)
                                        begin
                                            phase_next = pfci_pkg::PH_UNLOCK1;
                                        end
                                    end
                                    pfci_pkg::PH_UNLOCK1:
                                    begin
                                        if (addr_low == pfci_pkg::UNLOCK_ADDR2
                                            && write_byte == pfci_pkg::CMD_UNLOCK2)
                                        begin
                                            phase_next = pfci_pkg::PH_CMD;
                                        end
                                    end
                                    pfci_pkg::PH_CMD:
                                    begin
                                        if (addr_low == pfci_pkg::UNLOCK_ADDR1
                                            && write_byte == pfci_pkg::CMD_PROGRAM)
                                        begin
                                            phase_next = pfci_pkg::PH_PROGRAM;
                                        end
                                        else if (addr_low == pfci_pkg::UNLOCK_ADDR1
                                            && write_byte == pfci_pkg::CMD_ERASE_SETUP)
                                        begin
                                            phase_next = pfci_pkg::PH_ESETUP;
                                        end
                                    end
                                    pfci_pkg::PH_PROGRAM:
                                    begin
                                        ram_re          = 1'b1;
                                        prog_addr_next  = addr;
                                        prog_data_next  = write_byte;
                                        busy_count_next = ticks_cfg_reg;
                                        state_next      = pfci_pkg::ST_PROG_WRITE;
                                    end
                                    pfci_pkg::PH_ESETUP:
                                    begin
                                        if (addr_low == pfci_pkg::UNLOCK_ADDR1
                                            && write_byte == pfci_pkg::CMD_UNLOCK1)
                                        begin
                                            phase_next = pfci_pkg::PH_EUNLOCK1;
                                        end
                                    end
                                    pfci_pkg::PH_EUNLOCK1:
                                    begin
                                        if (addr_low == pfci_pkg::UNLOCK_ADDR2
                                            && write_byte == pfci_pkg::CMD_UNLOCK2)
                                        begin
                                            phase_next = pfci_pkg::PH_EUNLOCK2;
                                        end
                                    end
                                    pfci_pkg::PH_EUNLOCK2:
                                    begin
                                        if (addr_low == pfci_pkg::UNLOCK_ADDR1
                                            && write_byte == pfci_pkg::CMD_CHIP_ERASE)
                                        begin
                                            erase_ptr_next = '0;
                                            erase_end_next = '1;
                                            erase_run_next = 1'b1;
                                        end
                                        else if (write_byte == pfci_pkg::CMD_SECT_ERASE)
                                        begin
                                            erase_ptr_next = addr & ~SECTOR_MASK;
                                            erase_end_next = addr | SECTOR_MASK;
                                            erase_run_next = 1'b1;
                                        end
                                    end
                                    default:
                                    begin
                                        phase_next = pfci_pkg::PH_READ;
                                    end
                                endcase
                            end
                        end
                        pfci_pkg::KIND_TICK:
                        begin
                            imm_load = 1'b1;
                            if (erase_run_reg)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = erase_ptr_reg;
                                if (erase_ptr_reg >= erase_end_reg)
                                begin
                                    erase_run_next = 1'b0;
                                end
                                else
                                begin
                                    erase_ptr_next = erase_ptr_reg + ADDR_BITS'(1);
                                end
                            end
                            else if (busy_count_reg != 8'd0)
                            begin
                                busy_count_next = busy_count_reg - 8'd1;
                            end
                        end
                        default:
                        begin
                            imm_load = 1'b1;
                        end
                    endcase
                end
            end
            pfci_pkg::ST_READ_WAIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_read_next  = ram_rdata;
                    out_busy_next  = 1'b0;
                    state_next     = pfci_pkg::ST_IDLE;
                end
            end
            pfci_pkg::ST_PROG_WRITE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = prog_addr_reg;
                ram_wdata  = ram_rdata & prog_data_reg;
                state_next = pfci_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pfci_pkg::ST_IDLE;
            end
        endcase

        if (imm_load)
        begin
            out_valid_next = 1'b1;
            out_read_next  = imm_read;
            out_busy_next  = erase_run_next || (busy_count_next != 8'd0);
        end
    end

endmodule
`default_nettype wire
